// File: hdl/mraa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mraa_pkg: shared types and constants of the mark/release arena allocator
// Field widths, operation and status codes, and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package mraa_pkg;

	localparam int FIELD_W = 25;
	localparam int OP_W    = 2;
	localparam int ST_W    = 2;

	// arena is capped at 2^ARENA_BITS bytes
	localparam int ARENA_BITS = 24;
	localparam int CAP_SHIFT  = (ARENA_BITS < FIELD_W) ? ARENA_BITS : FIELD_W;
	localparam logic [FIELD_W:0] SIZE_CAP = {{FIELD_W{1'b0}}, 1'b1} << CAP_SHIFT;

	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
	localparam logic [OP_W-1:0] OP_MARK    = 2'd1;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic load;        // capture request fields
		logic commit;      // update state and load the result register
		logic scan_start;  // reset the mark search
		logic scan_step;   // issue one mark read / compare
	} dp_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            mark_empty;
		logic            scan_hit;
		logic            scan_miss;
	} dp_sts_t;

endpackage
`default_nettype wire

// File: hdl/mraa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mraa_datapath: allocator state, mark memory and result register
// Holds the bump offset, mark count, mark stack and effective size; runs the
// mark search one memory read per cycle under controller commands.
// ----------------------------------------------------------------------------
module mraa_datapath
	import mraa_pkg::*;
#(
	parameter int MARK_DEPTH = 1024
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr_en,
	input  wire logic [FIELD_W-1:0]  cfg_wr_data,
	input  wire logic [OP_W-1:0]     in_op,
	input  wire logic [FIELD_W-1:0]  in_amount,
	input  wire logic [FIELD_W-1:0]  in_target,
	input  wire dp_cmd_t             cmd,
	output dp_sts_t                  sts,
	output logic [FIELD_W-1:0]       out_block,
	output logic [ST_W-1:0]          out_status,
	output logic [FIELD_W-1:0]       out_used,
	output logic [FIELD_W-1:0]       out_free
);

	localparam int CW = $clog2(MARK_DEPTH + 1);
	localparam int IW = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(MARK_DEPTH);

	logic [FIELD_W-1:0] mark_mem [MARK_DEPTH];

	logic [FIELD_W-1:0] size_q;
	logic [FIELD_W-1:0] used_q;
	logic [CW-1:0]      count_q;
	logic [OP_W-1:0]    op_q;
	logic [FIELD_W-1:0] amount_q;
	logic [FIELD_W-1:0] target_q;
	logic [CW-1:0]      scan_idx_q;
	logic               rd_vld_s1;
	logic [CW-1:0]      rd_idx_s1;
	logic [FIELD_W-1:0] rd_data_s1;
	logic               found_q;
	logic [CW-1:0]      found_idx_q;
	logic [FIELD_W-1:0] found_val_q;

	logic [FIELD_W:0]   cfg_ext;
	logic [FIELD_W:0]   sum;
	logic               ovf;
	logic               full;
	logic               issue;
	logic               match;
	logic               last;
	logic [FIELD_W-1:0] free_alloc;
	logic [FIELD_W-1:0] free_hold;
	logic [FIELD_W-1:0] free_rel;

	assign cfg_ext    = {1'b0, cfg_wr_data};
	assign sum        = {1'b0, used_q} + {1'b0, amount_q};
	assign ovf        = sum > {1'b0, size_q};
	assign full       = count_q == DEPTH_C;
	assign issue      = scan_idx_q < count_q;
	assign match      = rd_vld_s1 && (rd_data_s1 == target_q);
	assign last       = (rd_idx_s1 + CW'(1)) == count_q;
	assign free_alloc = size_q - sum[FIELD_W-1:0];
	assign free_hold  = (size_q > used_q) ? size_q - used_q : '0;
	assign free_rel   = (size_q > found_val_q) ? size_q - found_val_q : '0;

	assign sts.op         = op_q;
	assign sts.mark_empty = count_q == '0;
	assign sts.scan_hit   = match;
	assign sts.scan_miss  = rd_vld_s1 && !match && last;

	// effective size register, capped at the arena limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
		end else if (cfg_wr_en) begin
			size_q <= (cfg_ext < SIZE_CAP) ? cfg_wr_data : SIZE_CAP[FIELD_W-1:0];
		end
	end

	// allocation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			count_q <= '0;
		end else if (cmd.commit) begin
			unique case (op_q)
				OP_ALLOC: begin
					if (!ovf) used_q <= sum[FIELD_W-1:0];
				end
				OP_MARK: begin
					if (!full) count_q <= count_q + CW'(1);
				end
				OP_RELEASE: begin
					if (found_q) begin
						count_q <= found_idx_q;
						used_q  <= found_val_q;
					end
				end
				OP_NONE: begin
				end
			endcase
		end
	end

	// request capture, search pipeline and result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= in_op;
			amount_q <= in_amount;
			target_q <= in_target;
		end
		if (cmd.scan_start) begin
			scan_idx_q <= '0;
			found_q    <= 1'b0;
		end else if (cmd.scan_step) begin
			scan_idx_q <= scan_idx_q + CW'(issue);
			if (match) begin
				found_q     <= 1'b1;
				found_idx_q <= rd_idx_s1;
				found_val_q <= rd_data_s1;
			end
		end
		rd_vld_s1 <= cmd.scan_step && issue;
		rd_idx_s1 <= scan_idx_q;
		if (cmd.commit) begin
			out_block  <= '0;
			out_status <= ST_OK;
			out_used   <= used_q;
			out_free   <= free_hold;
			unique case (op_q)
				OP_ALLOC: begin
					if (ovf) begin
						out_status <= ST_OVERFLOW;
					end else begin
						out_block <= used_q;
						out_used  <= sum[FIELD_W-1:0];
						out_free  <= free_alloc;
					end
				end
				OP_MARK: begin
					if (full) out_status <= ST_FULL;
				end
				OP_RELEASE: begin
					if (found_q) begin
						out_used <= found_val_q;
						out_free <= free_rel;
					end else begin
						out_status <= ST_NOT_FOUND;
					end
				end
				OP_NONE: begin
				end
			endcase
		end
	end

	// mark stack memory
	always_ff @(posedge clk) begin
		if (cmd.commit && op_q == OP_MARK && !full) begin
			mark_mem[count_q[IW-1:0]] <= used_q;
		end
		rd_data_s1 <= mark_mem[scan_idx_q[IW-1:0]];
	end

endmodule
`default_nettype wire

// File: hdl/mraa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mraa_ctrl: sequencer of the mark/release arena allocator
// Takes one request at a time, runs the mark search for releases and owns
// the output valid flag.
// ----------------------------------------------------------------------------
module mraa_ctrl
	import mraa_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_COMMIT
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   valid_q;
	logic   out_free;
	logic   accept;

	assign in_ready  = ready_q;
	assign out_valid = valid_q;
	assign out_free  = !valid_q || out_ready;
	assign accept    = in_valid && ready_q;

	always_comb begin
		cmd = '0;
		cmd.load = accept;
		unique case (state_q)
			S_IDLE: begin
			end
			S_EXEC: begin
				if (sts.op == OP_RELEASE) cmd.scan_start = 1'b1;
				else                      cmd.commit     = out_free;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			S_COMMIT: begin
				cmd.commit = out_free;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (cmd.commit)     valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					ready_q <= !accept;
					if (accept) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (sts.op == OP_RELEASE) begin
						state_q <= sts.mark_empty ? S_COMMIT : S_SCAN;
					end else if (out_free) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				S_SCAN: begin
					if (sts.scan_hit || sts.scan_miss) state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hdl/mark_release_arena_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mark_release_arena_allocator: bump allocator with a stack of release marks
// Allocates from a configured arena, pushes marks of the current offset and
// releases back to a stored mark; every transaction returns one result.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake           payload
//  s_*       in         s_tvalid/s_tready   tuser: operation; tdata: amount, target
//  m_*       out        m_tvalid/m_tready   tuser: status; tdata: block, used, free
//  cfg_*     in         cfg_wr_en           arena_size (write only)
//
// Allocate, mark and unused operations: the request is captured on accept and
// committed from S_EXEC into the output register, then the next request is taken.
// Release reads the mark stack from the bottom, one memory read per cycle,
// and stops at the lowest stored mark equal to the target; a miss reads all
// stored marks, and an empty stack skips the search before the commit.
// One request is in flight at a time; the next is taken once its result is in
// the output register, which holds while m_tready is low.
// Reset clears offset, mark count and arena size; the mark memory is not cleared.
//
module mark_release_arena_allocator
	import mraa_pkg::*;
#(
	parameter int MARK_DEPTH = 1024
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration
	input  wire logic                cfg_wr_en,
	input  wire logic [FIELD_W-1:0]  cfg_wr_data,  // arena_size
	// request stream
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [55:0]         s_tdata,      // [24:0] amount, [49:25] target_offset
	input  wire logic [1:0]          s_tuser,      // [1:0] operation
	// result stream
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [79:0]              m_tdata,      // [24:0] block_offset, [49:25] used_bytes,
	                                               // [74:50] free_bytes
	output logic [1:0]               m_tuser       // [1:0] status
);

	dp_cmd_t            cmd;
	dp_sts_t            sts;
	logic [FIELD_W-1:0] out_block;
	logic [FIELD_W-1:0] out_used;
	logic [FIELD_W-1:0] out_free;

	// controller: request sequencing and output valid
	mraa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: offset, marks, search and result register
	mraa_datapath #(
		.MARK_DEPTH (MARK_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_op       (s_tuser[OP_W-1:0]),
		.in_amount   (s_tdata[FIELD_W-1:0]),
		.in_target   (s_tdata[2*FIELD_W-1:FIELD_W]),
		.cmd         (cmd),
		.sts         (sts),
		.out_block   (out_block),
		.out_status  (m_tuser),
		.out_used    (out_used),
		.out_free    (out_free)
	);

	// pack result fields, zero fill to whole bytes
	assign m_tdata = {5'd0, out_free, out_used, out_block};

`ifndef ASSERT_OFF
	// a result is loaded only when the output register can take it
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!m_tvalid || m_tready))
		else $error("result loaded over a pending result");

	// one request in flight: ready drops right after an accept
	a_single_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while another is in flight");

	// the search never reports hit and miss together
	a_scan_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(sts.scan_hit && sts.scan_miss))
		else $error("mark search hit and miss at once");

	// every commit produces a valid result next cycle
	a_commit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid)
		else $error("commit without output valid");
`endif

endmodule
`default_nettype wire
